// ===== rtl/mrm_pkg.sv =====
// Shared types and constants of the multi-role mailbox.
package mrm_pkg;

   localparam logic MODE_SEND       = 1'b0;
   localparam int   CMD_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        mode;
      logic [1:0]  sender;
      logic [1:0]  receiver;
      logic [31:0] cmd_kind;
      logic [63:0] payload;
      logic [31:0] payload_len;
      logic [1:0]  urgency;
   } req_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_NO_RING = 2'd2,
      ST_NO_CMD  = 2'd3
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] got_kind;
      logic [63:0] got_payload;
      logic [31:0] got_len;
      logic [1:0]  got_urgency;
      logic [63:0] queued_total;
      logic [63:0] processed_total;
      logic [63:0] idle_total;
   } rsp_type;

   typedef enum logic [1:0] {
      CL_SEND,
      CL_SEND_BAD,
      CL_POLL,
      CL_POLL_BAD
   } class_type;

   typedef struct packed {
      class_type cls;
      logic      snd_ok;
      logic      rcv_ok;
      req_type   req;
   } job_type;

   typedef struct packed {
      logic [31:0] kind;
      logic [63:0] payload;
      logic [31:0] len;
      logic [1:0]  urgency;
   } slot_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_PTR,
      BK_DATA
   } back_state_type;

endpackage

// ===== rtl/multi_role_mailbox_fifos.sv =====
// A rejected send or empty poll finishes in the idle state; an accepted send reads the
// ring pointers, then writes the slot; a successful poll reads the pointers, then the slot.
// The back sequencer takes a new request only when idle and the result register is free;
// a 2-entry command queue takes requests meanwhile.
// Reset is synchronous: it clears the queue, ring flags, counters and result valid flag;
// the slot store is not cleared and no clearing pass is run.
module multi_role_mailbox_fifos import mrm_pkg::*; #(
   parameter int SLOTS = 64,
   parameter int ROLES = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   // classified request handed from front to back
   job_type cmd;
   logic    cmd_valid;
   logic    cmd_take;

   // front: check agent range and self-send, queue the request
   mrm_front #(
      .ROLES (ROLES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   // back: walk the rings, move slots, advance counters, hold the result
   mrm_back #(
      .SLOTS (SLOTS),
      .ROLES (ROLES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/mrm_front.sv =====
// Request intake: classify each request and hold it in a short command queue.
module mrm_front import mrm_pkg::*; #(
   parameter int ROLES = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    cmd_valid,
   output job_type cmd,
   input  logic    cmd_take
);

   localparam int QAW = $clog2(CMD_QUEUE_DEPTH);
   localparam int QCW = $clog2(CMD_QUEUE_DEPTH + 1);

   job_type          q_ff [CMD_QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCW-1:0]   cnt_ff, cnt_in;
   logic             push, pop;
   logic             snd_ok, rcv_ok;
   job_type          entry;

   assign req_full  = (cnt_ff == QCW'(CMD_QUEUE_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ff];
   assign push      = req_push && !req_full;
   assign pop       = cmd_take && cmd_valid;

   // classify the request once, on the way in
   always_comb begin
      snd_ok     = int'(req_data.sender) < ROLES;
      rcv_ok     = int'(req_data.receiver) < ROLES;
      entry.req    = req_data;
      entry.snd_ok = snd_ok;
      entry.rcv_ok = rcv_ok;
      if (req_data.mode == MODE_SEND) begin
         entry.cls = (snd_ok && rcv_ok && (req_data.sender != req_data.receiver)) ?
                     CL_SEND : CL_SEND_BAD;
      end else begin
         entry.cls = rcv_ok ? CL_POLL : CL_POLL_BAD;
      end
   end

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QAW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QAW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= entry;
      end
   end

endmodule

// ===== rtl/mrm_back.sv =====
// Command execution: ring pointers, slot store, per-agent counters, result register.
module mrm_back import mrm_pkg::*; #(
   parameter int SLOTS = 64,
   parameter int ROLES = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  job_type cmd,
   output logic    cmd_take,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int RINGS = ROLES * ROLES;
   localparam int RW    = $clog2(RINGS);
   localparam int PW    = $clog2(SLOTS);
   localparam int DEPTH = RINGS * SLOTS;
   localparam int DW    = $clog2(DEPTH);
   localparam int AW    = $clog2(ROLES);

   typedef struct packed {
      logic [PW-1:0] wptr;
      logic [PW-1:0] rptr;
   } ptr_pair_type;

   function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
      return (p == PW'(SLOTS - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [DW-1:0] slot_addr(input logic [RW-1:0] ring,
                                               input logic [PW-1:0] ptr);
      return DW'(ring) * DW'(SLOTS) + DW'(ptr);
   endfunction

   back_state_type state_ff, state_in;
   logic [RINGS-1:0] nonempty_ff, nonempty_in, full_ff, full_in, touched_ff, touched_in;
   logic [RW-1:0]    ring_ff, ring_in, ring_send, ring_poll;
   logic             poll_hit;

   ptr_pair_type     ptr_mem [RINGS];
   ptr_pair_type     ptr_rd_ff, ptr_q, ptr_wdata;
   logic             ptr_ok_ff;
   slot_type         data_mem [DEPTH];
   slot_type         data_rd_ff;
   logic [DW-1:0]    data_addr;

   logic [63:0]      sent_ff [ROLES], sent_in [ROLES];
   logic [63:0]      taken_ff [ROLES], taken_in [ROLES];
   logic [63:0]      idle_ff [ROLES], idle_in [ROLES];
   logic [63:0]      sent_new, taken_new, idle_new;

   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic [AW-1:0]    si, ri;
   logic             out_free, go, is_poll;
   logic             done, ptr_re, ptr_we, data_we, data_re;
   logic             inc_sent, inc_taken, inc_idle, got_ok;
   status_type       status;

   assign si        = AW'(cmd.req.sender);
   assign ri        = AW'(cmd.req.receiver);
   assign is_poll   = (cmd.cls == CL_POLL);
   assign out_free  = !out_valid_ff || rsp_pop;
   assign go        = (state_ff == BK_IDLE) && cmd_valid && out_free;
   assign ring_send = RW'(int'(si) * ROLES + int'(ri));
   assign ptr_q     = ptr_ok_ff ? ptr_rd_ff : '0;
   assign cmd_take  = done;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // lowest-numbered sender with a non-empty ring toward the receiver
   always_comb begin
      poll_hit  = 1'b0;
      ring_poll = '0;
      for (int p = ROLES - 1; p >= 0; p--) begin
         if ((AW'(p) != ri) && nonempty_ff[RW'(p * ROLES + int'(ri))]) begin
            poll_hit  = 1'b1;
            ring_poll = RW'(p * ROLES + int'(ri));
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (go) begin
               case (cmd.cls)
                  CL_SEND: begin
                     if (!full_ff[ring_send]) state_in = BK_PTR;
                  end
                  CL_POLL: begin
                     if (poll_hit) state_in = BK_PTR;
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_PTR:  state_in = is_poll ? BK_DATA : BK_IDLE;
         BK_DATA: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      done      = 1'b0;
      ptr_re    = 1'b0;
      ptr_we    = 1'b0;
      data_we   = 1'b0;
      data_re   = 1'b0;
      inc_sent  = 1'b0;
      inc_taken = 1'b0;
      inc_idle  = 1'b0;
      got_ok    = 1'b0;
      status    = ST_OK;
      ring_in   = ring_ff;
      ptr_wdata = ptr_q;
      data_addr = slot_addr(ring_ff, ptr_q.wptr);
      case (state_ff)
         BK_IDLE: begin
            if (go) begin
               case (cmd.cls)
                  CL_SEND: begin
                     ring_in = ring_send;
                     if (full_ff[ring_send]) begin
                        done   = 1'b1;
                        status = ST_FULL;
                     end else begin
                        ptr_re = 1'b1;
                     end
                  end
                  CL_SEND_BAD: begin
                     done   = 1'b1;
                     status = ST_NO_RING;
                  end
                  CL_POLL: begin
                     ring_in = ring_poll;
                     if (poll_hit) begin
                        ptr_re = 1'b1;
                     end else begin
                        done     = 1'b1;
                        status   = ST_NO_CMD;
                        inc_idle = 1'b1;
                     end
                  end
                  default: begin
                     done   = 1'b1;
                     status = ST_NO_CMD;
                  end
               endcase
            end
         end
         BK_PTR: begin
            ptr_we = 1'b1;
            if (is_poll) begin
               ptr_wdata.rptr = advance(ptr_q.rptr);
               data_re        = 1'b1;
               data_addr      = slot_addr(ring_ff, ptr_q.rptr);
            end else begin
               ptr_wdata.wptr = advance(ptr_q.wptr);
               data_we        = 1'b1;
               done           = 1'b1;
               inc_sent       = 1'b1;
            end
         end
         BK_DATA: begin
            done      = 1'b1;
            got_ok    = 1'b1;
            inc_taken = 1'b1;
         end
         default: ;
      endcase
   end

   // ring occupancy flags follow every pointer write
   always_comb begin
      nonempty_in = nonempty_ff;
      full_in     = full_ff;
      touched_in  = touched_ff;
      if (ptr_we) begin
         touched_in[ring_ff] = 1'b1;
         if (is_poll) begin
            nonempty_in[ring_ff] = (ptr_wdata.rptr != ptr_q.wptr);
            full_in[ring_ff]     = 1'b0;
         end else begin
            nonempty_in[ring_ff] = 1'b1;
            full_in[ring_ff]     = (advance(ptr_wdata.wptr) == ptr_q.rptr);
         end
      end
   end

   always_comb begin
      sent_new  = (cmd.snd_ok ? sent_ff[si] : 64'd0) + 64'(inc_sent);
      taken_new = (cmd.rcv_ok ? taken_ff[ri] : 64'd0) + 64'(inc_taken);
      idle_new  = (cmd.rcv_ok ? idle_ff[ri] : 64'd0) + 64'(inc_idle);
      sent_in   = sent_ff;
      taken_in  = taken_ff;
      idle_in   = idle_ff;
      if (inc_sent)  sent_in[si]  = sent_new;
      if (inc_taken) taken_in[ri] = taken_new;
      if (inc_idle)  idle_in[ri]  = idle_new;
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (done) begin
         out_valid_in           = 1'b1;
         out_in.status          = status;
         out_in.got_kind        = got_ok ? data_rd_ff.kind : '0;
         out_in.got_payload     = got_ok ? data_rd_ff.payload : '0;
         out_in.got_len         = got_ok ? data_rd_ff.len : '0;
         out_in.got_urgency     = got_ok ? data_rd_ff.urgency : '0;
         out_in.queued_total    = sent_new;
         out_in.processed_total = taken_new;
         out_in.idle_total      = idle_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         nonempty_ff  <= '0;
         full_ff      <= '0;
         touched_ff   <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < ROLES; i++) begin
            sent_ff[i]  <= '0;
            taken_ff[i] <= '0;
            idle_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         nonempty_ff  <= nonempty_in;
         full_ff      <= full_in;
         touched_ff   <= touched_in;
         out_valid_ff <= out_valid_in;
         sent_ff      <= sent_in;
         taken_ff     <= taken_in;
         idle_ff      <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      ring_ff <= ring_in;
      out_ff  <= out_in;
   end

   // pointer memory, one pair per ring; an untouched ring reads as zero
   always_ff @(posedge clock) begin
      if (ptr_we) begin
         ptr_mem[ring_ff] <= ptr_wdata;
      end
      if (ptr_re) begin
         ptr_rd_ff <= ptr_mem[ring_in];
         ptr_ok_ff <= touched_ff[ring_in];
      end
   end

   // slot store
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_addr] <= '{kind:    cmd.req.cmd_kind,
                                  payload: cmd.req.payload,
                                  len:     cmd.req.payload_len,
                                  urgency: cmd.req.urgency};
      end
      if (data_re) begin
         data_rd_ff <= data_mem[data_addr];
      end
   end

endmodule
